// File: rtl/ebca_pkg.sv
`default_nettype none
package ebca_pkg;

  localparam int FUNC_W = 5;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int BITIX_W = 3;
  localparam int FLAG_W = 4;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [FUNC_W-1:0] FN_ADD   = 5'd0;
  localparam logic [FUNC_W-1:0] FN_ADC   = 5'd1;
  localparam logic [FUNC_W-1:0] FN_SUB   = 5'd2;
  localparam logic [FUNC_W-1:0] FN_SBC   = 5'd3;
  localparam logic [FUNC_W-1:0] FN_AND   = 5'd4;
  localparam logic [FUNC_W-1:0] FN_XOR   = 5'd5;
  localparam logic [FUNC_W-1:0] FN_OR    = 5'd6;
  localparam logic [FUNC_W-1:0] FN_CP    = 5'd7;
  localparam logic [FUNC_W-1:0] FN_INC   = 5'd8;
  localparam logic [FUNC_W-1:0] FN_DEC   = 5'd9;
  localparam logic [FUNC_W-1:0] FN_DAA   = 5'd10;
  localparam logic [FUNC_W-1:0] FN_CPL   = 5'd11;
  localparam logic [FUNC_W-1:0] FN_CCF   = 5'd12;
  localparam logic [FUNC_W-1:0] FN_SCF   = 5'd13;
  localparam logic [FUNC_W-1:0] FN_RLCA  = 5'd14;
  localparam logic [FUNC_W-1:0] FN_RRCA  = 5'd15;
  localparam logic [FUNC_W-1:0] FN_RLA   = 5'd16;
  localparam logic [FUNC_W-1:0] FN_RRA   = 5'd17;
  localparam logic [FUNC_W-1:0] FN_RLC   = 5'd18;
  localparam logic [FUNC_W-1:0] FN_RRC   = 5'd19;
  localparam logic [FUNC_W-1:0] FN_RL    = 5'd20;
  localparam logic [FUNC_W-1:0] FN_RR    = 5'd21;
  localparam logic [FUNC_W-1:0] FN_SLA   = 5'd22;
  localparam logic [FUNC_W-1:0] FN_SRA   = 5'd23;
  localparam logic [FUNC_W-1:0] FN_SWAP  = 5'd24;
  localparam logic [FUNC_W-1:0] FN_SRL   = 5'd25;
  localparam logic [FUNC_W-1:0] FN_BIT   = 5'd26;
  localparam logic [FUNC_W-1:0] FN_RES   = 5'd27;
  localparam logic [FUNC_W-1:0] FN_SET   = 5'd28;
  localparam logic [FUNC_W-1:0] FN_ADD16 = 5'd29;
  localparam logic [FUNC_W-1:0] FN_ADDSP = 5'd30;

  localparam logic [BYTE_W-1:0] DAA_LIMIT = 8'h99;
  localparam logic [BYTE_W-1:0] DAA_LO    = 8'h06;
  localparam logic [BYTE_W-1:0] DAA_HI    = 8'h60;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [WORD_W-1:0]  operand_a;
    logic [WORD_W-1:0]  operand_b;
    logic [BITIX_W-1:0] bit_index;
    logic [FLAG_W-1:0]  flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic [FLAG_W-1:0] flags_out;
    logic              write_result;
  } alu_out_t;

endpackage
`default_nettype wire

// File: rtl/ebca_alu.sv
`default_nettype none
module ebca_alu (
  input  ebca_pkg::alu_in_t  op_in,
  output ebca_pkg::alu_out_t op_out
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;
  logic        cin;
  logic        c;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [7:0]  res8;
  logic [7:0]  adj;
  logic        cout;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] res16;
  logic [3:0]  fo;
  logic        wr;
  logic        wide;

  assign a   = op_in.operand_a[7:0];
  assign b   = op_in.operand_b[7:0];
  assign f   = op_in.flags_in;
  assign cin = f[ebca_pkg::FLAG_C];

  always_comb begin
    c     = ((op_in.func == ebca_pkg::FN_ADC) || (op_in.func == ebca_pkg::FN_SBC)) & cin;
    sum9  = {1'b0, a} + {1'b0, b} + {8'd0, c};
    sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
    dif9  = {1'b0, a} - {1'b0, b} - {8'd0, c};
    dif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
    sum17 = {1'b0, op_in.operand_a} + {1'b0, op_in.operand_b};
    sum13 = {1'b0, op_in.operand_a[11:0]} + {1'b0, op_in.operand_b[11:0]};
    res8  = 8'd0;
    res16 = 16'd0;
    adj   = 8'd0;
    cout  = 1'b0;
    fo    = f;
    wr    = 1'b1;
    wide  = 1'b0;
    case (op_in.func)
      ebca_pkg::FN_ADD, ebca_pkg::FN_ADC: begin
        res8 = sum9[7:0];
        fo   = {res8 == 8'd0, 1'b0, sum5[4], sum9[8]};
      end
      ebca_pkg::FN_SUB, ebca_pkg::FN_SBC, ebca_pkg::FN_CP: begin
        res8 = dif9[7:0];
        fo   = {res8 == 8'd0, 1'b1, dif5[4], dif9[8]};
        if (op_in.func == ebca_pkg::FN_CP) begin
          res8 = 8'd0;
          wr   = 1'b0;
        end
      end
      ebca_pkg::FN_AND: begin
        res8 = a & b;
        fo   = {res8 == 8'd0, 3'b010};
      end
      ebca_pkg::FN_XOR: begin
        res8 = a ^ b;
        fo   = {res8 == 8'd0, 3'b000};
      end
      ebca_pkg::FN_OR: begin
        res8 = a | b;
        fo   = {res8 == 8'd0, 3'b000};
      end
      ebca_pkg::FN_INC: begin
        res8 = b + 8'd1;
        fo   = {res8 == 8'd0, 1'b0, b[3:0] == 4'hF, cin};
      end
      ebca_pkg::FN_DEC: begin
        res8 = b - 8'd1;
        fo   = {res8 == 8'd0, 1'b1, b[3:0] == 4'h0, cin};
      end
      ebca_pkg::FN_DAA: begin
        cout = cin;
        if (!f[ebca_pkg::FLAG_N]) begin
          if (f[ebca_pkg::FLAG_H] || (a[3:0] > 4'd9)) begin
            adj = adj | ebca_pkg::DAA_LO;
          end
          if (cin || (a > ebca_pkg::DAA_LIMIT)) begin
            adj  = adj | ebca_pkg::DAA_HI;
            cout = 1'b1;
          end
          res8 = a + adj;
        end else begin
          if (f[ebca_pkg::FLAG_H]) begin
            adj = adj | ebca_pkg::DAA_LO;
          end
          if (cin) begin
            adj = adj | ebca_pkg::DAA_HI;
          end
          res8 = a - adj;
        end
        fo = {res8 == 8'd0, f[ebca_pkg::FLAG_N], 1'b0, cout};
      end
      ebca_pkg::FN_CPL: begin
        res8 = ~a;
        fo   = f | 4'b0110;
      end
      ebca_pkg::FN_CCF: begin
        res8 = a;
        fo   = {f[ebca_pkg::FLAG_Z], 2'b00, ~cin};
      end
      ebca_pkg::FN_SCF: begin
        res8 = a;
        fo   = {f[ebca_pkg::FLAG_Z], 3'b001};
      end
      ebca_pkg::FN_RLCA: begin
        cout = a[7];
        res8 = {a[6:0], a[7]};
        fo   = {f[ebca_pkg::FLAG_Z], 2'b00, cout};
      end
      ebca_pkg::FN_RRCA: begin
        cout = a[0];
        res8 = {a[0], a[7:1]};
        fo   = {f[ebca_pkg::FLAG_Z], 2'b00, cout};
      end
      ebca_pkg::FN_RLA: begin
        cout = a[7];
        res8 = {a[6:0], cin};
        fo   = {f[ebca_pkg::FLAG_Z], 2'b00, cout};
      end
      ebca_pkg::FN_RRA: begin
        cout = a[0];
        res8 = {cin, a[7:1]};
        fo   = {f[ebca_pkg::FLAG_Z], 2'b00, cout};
      end
      ebca_pkg::FN_RLC: begin
        cout = b[7];
        res8 = {b[6:0], b[7]};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_RRC: begin
        cout = b[0];
        res8 = {b[0], b[7:1]};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_RL: begin
        cout = b[7];
        res8 = {b[6:0], cin};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_RR: begin
        cout = b[0];
        res8 = {cin, b[7:1]};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_SLA: begin
        cout = b[7];
        res8 = {b[6:0], 1'b0};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_SRA: begin
        cout = b[0];
        res8 = {b[7], b[7:1]};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_SWAP: begin
        res8 = {b[3:0], b[7:4]};
        fo   = {res8 == 8'd0, 3'b000};
      end
      ebca_pkg::FN_SRL: begin
        cout = b[0];
        res8 = {1'b0, b[7:1]};
        fo   = {res8 == 8'd0, 2'b00, cout};
      end
      ebca_pkg::FN_BIT: begin
        fo = {~b[op_in.bit_index], 2'b01, cin};
        wr = 1'b0;
      end
      ebca_pkg::FN_RES: begin
        res8 = b & ~(8'd1 << op_in.bit_index);
      end
      ebca_pkg::FN_SET: begin
        res8 = b | (8'd1 << op_in.bit_index);
      end
      ebca_pkg::FN_ADD16: begin
        wide  = 1'b1;
        res16 = sum17[15:0];
        fo    = {f[ebca_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      ebca_pkg::FN_ADDSP: begin
        wide  = 1'b1;
        res16 = op_in.operand_a + {{8{b[7]}}, b};
        fo    = {2'b00, sum5[4], sum9[8]};
      end
      default: begin
        fo = f;
        wr = 1'b0;
      end
    endcase
    op_out.result       = wide ? res16 : {8'd0, res8};
    op_out.flags_out    = fo;
    op_out.write_result = wr;
  end

endmodule
`default_nettype wire

// File: rtl/eight_bit_cpu_alu_with_flags_core.sv
// Each input transfer passes through an input register and then a result register.
// Throughput: one item per cycle while the output is not stalled; the input register feeds
// the flag and result logic, which loads a result register.
// A new item is taken while a finished result waits, as long as the input register is empty.
// Reset (rst, synchronous, active high) clears both valid flags; data registers keep theirs.
`default_nettype none
module eight_bit_cpu_alu_with_flags_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: operand_a[15:0], operand_b[31:16], bit_index[34:32],
  // flags_in[38:35], zero pad[39].
  input  wire logic [ebca_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: func[4:0].
  input  wire logic [4:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0: result[15:0], flags_out[19:16], zero pad[23:20].
  output logic [ebca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: write_result[0].
  output logic             m_axis_tuser
);

  ebca_pkg::alu_in_t  in_reg;
  logic               in_valid;
  ebca_pkg::alu_out_t alu_res;
  ebca_pkg::alu_out_t out_reg;
  logic               out_valid;
  logic               out_load;

  assign out_load      = ~out_valid | m_axis_tready;
  assign s_axis_tready = ~in_valid | out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_reg.func      <= s_axis_tuser;
      in_reg.operand_a <= s_axis_tdata[15:0];
      in_reg.operand_b <= s_axis_tdata[31:16];
      in_reg.bit_index <= s_axis_tdata[34:32];
      in_reg.flags_in  <= s_axis_tdata[38:35];
    end
  end

  ebca_alu u_alu (
    .op_in  (in_reg),
    .op_out (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_reg <= alu_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_reg.flags_out, out_reg.result};
  assign m_axis_tuser  = out_reg.write_result;

endmodule
`default_nettype wire

// File: rtl/ebca_checker.sv
`default_nettype none
module ebca_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output valid after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled with an empty output.");

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("Result missing two cycles after an input transfer.");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("Result not zero on an item without writeback.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("Stalled output transfer changed.");

endmodule

bind eight_bit_cpu_alu_with_flags_core ebca_checker u_ebca_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
